### rtl/kclk_pkg.sv
package kclk_pkg;

   localparam int MotorPhases = 4;

   // event codes of a result item
   localparam logic [2:0] EvTick    = 3'd0;
   localparam logic [2:0] EvDigit   = 3'd1;
   localparam logic [2:0] EvMatch   = 3'd2;
   localparam logic [2:0] EvWrong   = 3'd3;
   localparam logic [2:0] EvLockout = 3'd4;
   localparam logic [2:0] EvIgnored = 3'd5;

   // request kinds
   localparam logic ReqKey  = 1'b0;
   localparam logic ReqTick = 1'b1;

   // configuration register indexes
   localparam logic [2:0] CsrCodeFirst    = 3'd0;
   localparam logic [2:0] CsrCodeSecond   = 3'd1;
   localparam logic [2:0] CsrCodeThird    = 3'd2;
   localparam logic [2:0] CsrCodeFourth   = 3'd3;
   localparam logic [2:0] CsrFailureLimit = 3'd4;
   localparam logic [2:0] CsrLockoutTicks = 3'd5;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 10;

   localparam logic [3:0] MaxFailures = 4'hF;
   localparam logic [3:0] MaxDigit    = 4'd9;

   typedef struct packed {
      logic [3:0][3:0] code_digit;
      logic [3:0]      failure_limit;
      logic [9:0]      lockout_ticks;
   } cfg_type;

   // coil drive for motor phase 1..4, idle otherwise
   function automatic logic [3:0] coil_for_phase(input logic [2:0] phase);
      logic [3:0] coil;
      case (phase)
         3'd1:    coil = 4'h6;
         3'd2:    coil = 4'h3;
         3'd3:    coil = 4'h9;
         3'd4:    coil = 4'hC;
         default: coil = 4'h0;
      endcase
      return coil;
   endfunction

endpackage

### rtl/kclk_if.sv
interface kclk_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [1:0] key_row;
   logic [1:0] key_col;

   modport source (output valid, output req_type, output key_row, output key_col,
                   input ready);
   modport sink (input valid, input req_type, input key_row, input key_col,
                 output ready);
endinterface

interface kclk_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] event_code;
   logic [1:0] digits_entered;
   logic [3:0] coil_pattern;
   logic       locked_out;
   logic [3:0] failure_count;

   modport source (output valid, output event_code, output digits_entered,
                   output coil_pattern, output locked_out, output failure_count,
                   input ready);
   modport sink (input valid, input event_code, input digits_entered,
                 input coil_pattern, input locked_out, input failure_count,
                 output ready);
endinterface

### rtl/kclk_csr.sv
module kclk_csr
   import kclk_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wr_data,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CsrCodeFirst:    cfg_in.code_digit[0] = csr_wr_data[3:0];
            CsrCodeSecond:   cfg_in.code_digit[1] = csr_wr_data[3:0];
            CsrCodeThird:    cfg_in.code_digit[2] = csr_wr_data[3:0];
            CsrCodeFourth:   cfg_in.code_digit[3] = csr_wr_data[3:0];
            CsrFailureLimit: cfg_in.failure_limit = csr_wr_data[3:0];
            CsrLockoutTicks: cfg_in.lockout_ticks = csr_wr_data[9:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.code_digit[0] <= 4'd1;
         cfg_ff.code_digit[1] <= 4'd2;
         cfg_ff.code_digit[2] <= 4'd3;
         cfg_ff.code_digit[3] <= 4'd7;
         cfg_ff.failure_limit <= 4'd4;
         cfg_ff.lockout_ticks <= 10'd30;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/keypad_code_lock_with_lockout_unit.sv
// Latency: a result item is valid in the cycle after its request item is accepted.
// Throughput: one item per cycle; the whole state update is one pass of logic
// into the state and result registers, and a held result stalls only if not taken.
// Reset (synchronous, active high): code 1-2-3-7, failure limit 4, lockout 30 ticks,
// entry cleared, motor idle, no lockout, no result pending.
module keypad_code_lock_with_lockout_unit
   import kclk_pkg::*;
#(
   parameter int CODE_LENGTH = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   kclk_req_if.sink                 req_ch,
   kclk_rsp_if.source               rsp_ch,
   input  logic                     csr_wr_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wr_data
);

   localparam logic [1:0] LastPos = 2'(CODE_LENGTH - 1);

   cfg_type cfg;

   kclk_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   logic [1:0] pos_ff, pos_in;
   logic       all_ff, all_in;
   logic [3:0] fail_ff, fail_in;
   logic [9:0] lock_ff, lock_in;
   logic [2:0] motor_ff, motor_in;
   logic [2:0] event_in;

   logic       rsp_valid_ff;
   logic [2:0] event_ff;
   logic [1:0] digits_ff;
   logic [3:0] coil_ff;
   logic       locked_ff;
   logic [3:0] count_ff;

   logic       accept;
   logic       busy;
   logic [3:0] key;
   logic       hit;
   logic       match_next;
   logic [3:0] fail_inc;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   assign busy       = (motor_ff != 3'd0) || (lock_ff != 10'd0);
   assign key        = {req_ch.key_row, req_ch.key_col};
   assign hit        = (key <= MaxDigit) && (key == cfg.code_digit[pos_ff]);
   assign match_next = all_ff && hit;
   assign fail_inc   = (fail_ff < MaxFailures) ? fail_ff + 4'd1 : MaxFailures;

   always_comb begin
      pos_in   = pos_ff;
      all_in   = all_ff;
      fail_in  = fail_ff;
      lock_in  = lock_ff;
      motor_in = motor_ff;
      event_in = EvTick;
      if (req_ch.req_type == ReqTick) begin
         if (lock_ff != 10'd0) lock_in = lock_ff - 10'd1;
         if (motor_ff != 3'd0) begin
            motor_in = (motor_ff >= 3'(MotorPhases)) ? 3'd0 : motor_ff + 3'd1;
         end
      end else if (busy) begin
         event_in = EvIgnored;
      end else if (pos_ff != LastPos) begin
         pos_in   = pos_ff + 2'd1;
         all_in   = match_next;
         event_in = EvDigit;
      end else begin
         // entry complete: settle match or failure, start a new entry
         pos_in = 2'd0;
         all_in = 1'b1;
         if (match_next) begin
            fail_in  = 4'd0;
            motor_in = 3'd1;
            event_in = EvMatch;
         end else if (fail_inc >= cfg.failure_limit) begin
            fail_in  = 4'd0;
            lock_in  = cfg.lockout_ticks;
            event_in = EvLockout;
         end else begin
            fail_in  = fail_inc;
            event_in = EvWrong;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 2'd0;
         all_ff       <= 1'b1;
         fail_ff      <= 4'd0;
         lock_ff      <= 10'd0;
         motor_ff     <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            pos_ff   <= pos_in;
            all_ff   <= all_in;
            fail_ff  <= fail_in;
            lock_ff  <= lock_in;
            motor_ff <= motor_in;
         end
         if (accept) rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready) rsp_valid_ff <= 1'b0;
      end
   end

   // result payload: hold until taken
   always_ff @(posedge clock) begin
      if (accept) begin
         event_ff  <= event_in;
         digits_ff <= pos_in;
         coil_ff   <= coil_for_phase(motor_in);
         locked_ff <= (lock_in != 10'd0);
         count_ff  <= fail_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.event_code     = event_ff;
   assign rsp_ch.digits_entered = digits_ff;
   assign rsp_ch.coil_pattern   = coil_ff;
   assign rsp_ch.locked_out     = locked_ff;
   assign rsp_ch.failure_count  = count_ff;

endmodule
